/* hdl/cfsg_pkg.sv */
package cfsg_pkg;

  // recognised frames: identifier and data length
  localparam logic [31:0] KeyFrameId     = 32'h92F85150;
  localparam logic [31:0] DoorAFrameId   = 32'h92F83010;
  localparam logic [31:0] DoorBFrameId   = 32'h92F84010;
  localparam logic [31:0] DoorCFrameId   = 32'h92F84310;
  localparam logic [31:0] BrightFrameId  = 32'h92F85450;
  localparam logic [31:0] LampFrameId    = 32'h8AF81110;
  localparam logic [31:0] SpeedFrameId   = 32'h92F85050;
  localparam logic [31:0] TempFrameId    = 32'h92F96250;
  localparam logic [31:0] CoolantFrameId = 32'h92F85250;

  localparam logic [3:0] KeyFrameLen     = 4'd5;
  localparam logic [3:0] DoorFrameLen    = 4'd1;
  localparam logic [3:0] BrightFrameLen  = 4'd8;
  localparam logic [3:0] LampFrameLen    = 4'd2;
  localparam logic [3:0] SpeedFrameLen   = 4'd5;
  localparam logic [3:0] TempFrameLen    = 4'd7;
  localparam logic [3:0] CoolantFrameLen = 4'd4;

  // key byte codes and key positions
  localparam logic [7:0] KeyCodeRun    = 8'h02;
  localparam logic [7:0] KeyCodeAccA   = 8'h40;
  localparam logic [7:0] KeyCodeAccB   = 8'h60;
  localparam logic [7:0] KeyCodeLocked = 8'h00;
  localparam logic [2:0] KeyPosOff     = 3'd0;
  localparam logic [2:0] KeyPosRun     = 3'd1;
  localparam logic [2:0] KeyPosAcc     = 3'd2;
  localparam logic [2:0] KeyPosLocked  = 3'd4;

  // message bytes
  localparam logic [7:0] BroadcastPrefix = 8'hA1;
  localparam logic [7:0] MsgKindKey      = 8'h02;
  localparam logic [7:0] MsgKindDoors    = 8'h43;
  localparam logic [7:0] MsgKindBright   = 8'h10;
  localparam logic [7:0] MsgKindLamps    = 8'h11;
  localparam logic [7:0] MsgKindGauge    = 8'h1F;
  localparam logic [7:0] GaugeTemp       = 8'h03;
  localparam logic [7:0] GaugeSpeed      = 8'h04;
  localparam logic [7:0] GaugeCoolant    = 8'h05;
  localparam logic [7:0] SpeedUnit       = 8'h01;
  localparam logic [7:0] TempFlagBase    = 8'h12;
  localparam logic [7:0] TempFlagNeg     = 8'h08;
  localparam logic [7:0] TempFlagFahr    = 8'h80;
  localparam logic [7:0] CoolFlagBase    = 8'h81;
  localparam logic [7:0] CoolFlagNeg     = 8'h08;
  localparam logic [7:0] NormFull        = 8'hFF;

  localparam logic [2:0] LenKey     = 3'd3;
  localparam logic [2:0] LenDoors   = 3'd3;
  localparam logic [2:0] LenBright  = 3'd4;
  localparam logic [2:0] LenLamps   = 3'd4;
  localparam logic [2:0] LenSpeed   = 3'd5;
  localparam logic [2:0] LenCoolant = 3'd5;
  localparam logic [2:0] LenTemp    = 3'd6;

  // reset values of the stored state
  localparam logic [4:0]  BrightReset    = 5'd22;
  localparam logic [4:0]  BrightFull     = 5'd22;
  localparam logic [13:0] ShownTempReset = 14'd50;
  localparam logic [7:0]  CoolantReset   = 8'd53;

  // temperature conversion constants
  localparam logic [7:0]  RawOffset    = 8'd40;   // raw value of zero degrees
  localparam logic [7:0]  RawFreezing  = 8'd72;   // raw value of 32 degrees
  localparam logic [7:0]  RawFahrSign  = 8'd23;   // below this 9*raw-200 is negative
  localparam logic [11:0] FahrOffset   = 12'd200;
  localparam logic [12:0] Recip9       = 13'd7282;  // 2^16/9 rounded up
  localparam logic [13:0] Recip5       = 14'd13108; // 2^16/5 rounded up
  localparam logic [7:0]  CoolOffset   = 8'd40;

  localparam int unsigned MaxMsgs = 3;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;
  } in_item_t;

  typedef struct packed {
    logic [2:0] msg_len;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        neg;
    logic [12:0] mag;
  } temp_val_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    out_item_t [MaxMsgs-1:0]      msg;
  } msg_burst_t;

  typedef enum logic [3:0] {
    FrameNone,
    FrameKey,
    FrameDoorA,
    FrameDoorB,
    FrameDoorC,
    FrameBright,
    FrameLamps,
    FrameSpeed,
    FrameTemp,
    FrameCoolant
  } frame_kind_e;

  // build one message with the broadcast prefix
  function automatic out_item_t mk_msg(input logic [2:0] len, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic [7:0] b4, input logic [7:0] b5);
    out_item_t m;
    m.msg_len = len;
    m.byte_0  = BroadcastPrefix;
    m.byte_1  = b1;
    m.byte_2  = b2;
    m.byte_3  = b3;
    m.byte_4  = b4;
    m.byte_5  = b5;
    m.last    = 1'b0;
    return m;
  endfunction

endpackage

/* hdl/cfsg_temp_conv.sv */
module cfsg_temp_conv (
  input  logic                 show_celsius_i,
  input  logic                 src_fahrenheit_i,
  input  logic [7:0]           raw_i,
  output cfsg_pkg::temp_val_t  temp_o
);
  import cfsg_pkg::*;

  logic        c_neg;
  logic [7:0]  c_dist;
  logic [10:0] c_x;
  logic [23:0] c_prod;
  logic [7:0]  c_q;
  logic [12:0] c_mag;

  logic        f_neg;
  logic [11:0] f_nine;
  logic [12:0] f_x;
  logic [25:0] f_prod;
  logic [9:0]  f_q;
  logic [12:0] f_mag;

  logic        s_neg;
  logic [7:0]  s_dist;
  logic [12:0] s_mag;

  logic        sel_neg;
  logic [12:0] sel_mag;

  // fahrenheit source shown in celsius: 5*floor(10k/9) or -10*floor(5|k|/9), k = raw-72
  assign c_neg  = raw_i < RawFreezing;
  assign c_dist = c_neg ? (RawFreezing - raw_i) : (raw_i - RawFreezing);
  assign c_x    = c_neg ? ((11'(c_dist) << 2) + 11'(c_dist))
                        : ((11'(c_dist) << 3) + (11'(c_dist) << 1));
  assign c_prod = 24'(c_x) * 24'(Recip9);
  assign c_q    = c_prod[23:16];
  assign c_mag  = c_neg ? ((13'(c_q) << 3) + (13'(c_q) << 1))
                        : ((13'(c_q) << 2) + 13'(c_q));

  // celsius source shown in fahrenheit: t = 2u, u = 9*raw-200
  assign f_neg  = raw_i < RawFahrSign;
  assign f_nine = (12'(raw_i) << 3) + 12'(raw_i);
  assign f_x    = f_neg ? 13'(FahrOffset - f_nine) : {f_nine - FahrOffset, 1'b0};
  assign f_prod = 26'(f_x) * 26'(Recip5);
  assign f_q    = f_prod[25:16];
  assign f_mag  = f_neg ? ((13'(f_q) << 3) + (13'(f_q) << 1))
                        : ((13'(f_q) << 2) + 13'(f_q));

  // same unit: ten times the offset value
  assign s_neg  = raw_i < RawOffset;
  assign s_dist = s_neg ? (RawOffset - raw_i) : (raw_i - RawOffset);
  assign s_mag  = (13'(s_dist) << 3) + (13'(s_dist) << 1);

  // pick the path, a zero magnitude is never negative
  always_comb begin
    if (show_celsius_i != src_fahrenheit_i) begin
      sel_neg = s_neg;
      sel_mag = s_mag;
    end else if (show_celsius_i) begin
      sel_neg = c_neg;
      sel_mag = c_mag;
    end else begin
      sel_neg = f_neg;
      sel_mag = f_mag;
    end
  end

  assign temp_o.neg = sel_neg && (sel_mag != '0);
  assign temp_o.mag = sel_mag;

endmodule

/* hdl/cfsg_frame_proc.sv */
module cfsg_frame_proc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  show_celsius_i,
  input  cfsg_pkg::in_item_t    frame_i,
  output cfsg_pkg::msg_burst_t  burst_o
);
  import cfsg_pkg::*;

  typedef struct packed {
    logic [2:0]  key_position;
    logic [7:0]  door_bits;
    logic [4:0]  dash_brightness;
    logic        headlights_on;
    logic        night_flag;
    logic [7:0]  front_lamp_bits;
    logic [7:0]  rear_lamp_bits;
    logic [7:0]  speed_value;
    logic [7:0]  raw_outside_temp;
    logic        source_fahrenheit;
    logic [13:0] shown_outside_temp;
    logic [7:0]  raw_coolant_temp;
  } veh_state_t;

  veh_state_t  st_q, st_d;
  frame_kind_e kind;
  temp_val_t   temp;
  logic [13:0] shown_new;
  logic [2:0]  key_new;
  logic [7:0]  front_new;
  logic [7:0]  rear_new;
  logic        hood_new;
  logic [7:0]  norm;
  logic [7:0]  temp_flags;
  logic        cool_low;
  logic [7:0]  cool_mag;
  logic [1:0]  door_cnt;
  out_item_t   doors_item;

  // frame decode
  always_comb begin
    priority if (frame_i.frame_id == KeyFrameId && frame_i.frame_len == KeyFrameLen) begin
      kind = FrameKey;
    end else if (frame_i.frame_id == DoorAFrameId && frame_i.frame_len == DoorFrameLen) begin
      kind = FrameDoorA;
    end else if (frame_i.frame_id == DoorBFrameId && frame_i.frame_len == DoorFrameLen) begin
      kind = FrameDoorB;
    end else if (frame_i.frame_id == DoorCFrameId && frame_i.frame_len == DoorFrameLen) begin
      kind = FrameDoorC;
    end else if (frame_i.frame_id == BrightFrameId && frame_i.frame_len == BrightFrameLen) begin
      kind = FrameBright;
    end else if (frame_i.frame_id == LampFrameId && frame_i.frame_len == LampFrameLen) begin
      kind = FrameLamps;
    end else if (frame_i.frame_id == SpeedFrameId && frame_i.frame_len == SpeedFrameLen) begin
      kind = FrameSpeed;
    end else if (frame_i.frame_id == TempFrameId && frame_i.frame_len == TempFrameLen) begin
      kind = FrameTemp;
    end else if (frame_i.frame_id == CoolantFrameId
                 && frame_i.frame_len == CoolantFrameLen) begin
      kind = FrameCoolant;
    end else begin
      kind = FrameNone;
    end
  end

  // key byte to key position, unknown codes keep the key
  always_comb begin
    priority if (frame_i.data_2 == KeyCodeRun) begin
      key_new = KeyPosRun;
    end else if (frame_i.data_2 == KeyCodeAccA || frame_i.data_2 == KeyCodeAccB) begin
      key_new = KeyPosAcc;
    end else if (frame_i.data_2 == KeyCodeLocked) begin
      key_new = KeyPosLocked;
    end else begin
      key_new = st_q.key_position;
    end
  end

  // lamp and hood bits
  assign front_new = {3'b000, frame_i.data_1[7], frame_i.data_0[6], frame_i.data_0[0],
                      frame_i.data_0[1], frame_i.data_0[3]};
  assign rear_new  = {2'b00, frame_i.data_1[6], frame_i.data_1[3], 4'b0000};
  assign hood_new  = frame_i.data_0[7];

  // outside temperature
  cfsg_temp_conv u_temp_conv (
    .show_celsius_i   (show_celsius_i),
    .src_fahrenheit_i (frame_i.data_0[1]),
    .raw_i            (frame_i.data_2),
    .temp_o           (temp)
  );

  assign shown_new  = temp.neg ? (14'd0 - {1'b0, temp.mag}) : {1'b0, temp.mag};
  assign temp_flags = TempFlagBase | (temp.neg ? TempFlagNeg : 8'h00)
                      | (show_celsius_i ? 8'h00 : TempFlagFahr);

  // coolant magnitude and sign
  assign cool_low = frame_i.data_0 < CoolOffset;
  assign cool_mag = cool_low ? (CoolOffset - frame_i.data_0) : (frame_i.data_0 - CoolOffset);

  assign door_cnt = (st_q.key_position == KeyPosOff) ? 2'd2 : 2'd1;

  // next state and message burst
  always_comb begin
    st_d       = st_q;
    burst_o    = '0;
    doors_item = '0;
    norm       = '0;
    unique case (kind)
      FrameKey: begin
        st_d.key_position = key_new;
        burst_o.msg[0] = mk_msg(LenKey, MsgKindKey, {5'b00000, key_new}, 8'h00, 8'h00, 8'h00);
        burst_o.msg[1] = burst_o.msg[0];
        if (key_new != st_q.key_position) begin
          burst_o.cnt = (st_q.key_position == KeyPosOff) ? 2'd2 : 2'd1;
        end
      end
      FrameDoorA, FrameDoorB, FrameDoorC: begin
        if (kind == FrameDoorA) begin
          st_d.door_bits[1] = frame_i.data_0[5];
          st_d.door_bits[3] = frame_i.data_0[7];
        end else if (kind == FrameDoorB) begin
          st_d.door_bits[0] = frame_i.data_0[4];
          st_d.door_bits[2] = frame_i.data_0[6];
        end else begin
          st_d.door_bits[4] = frame_i.data_0[7];
        end
        doors_item = mk_msg(LenDoors, MsgKindDoors, st_d.door_bits, 8'h00, 8'h00, 8'h00);
        burst_o.msg[0] = doors_item;
        burst_o.msg[1] = doors_item;
        if (st_d.door_bits != st_q.door_bits) begin
          burst_o.cnt = door_cnt;
        end
      end
      FrameBright: begin
        st_d.dash_brightness = frame_i.data_0[4:0];
        st_d.headlights_on   = frame_i.data_0[6];
        st_d.night_flag      = frame_i.data_5[6];
        if (st_d.dash_brightness >= BrightFull) begin
          norm = NormFull;
        end else begin
          norm = (8'(st_d.dash_brightness) << 3) + (8'(st_d.dash_brightness) << 1)
                 + 8'(st_d.dash_brightness);
        end
        burst_o.msg[0] = mk_msg(LenBright, MsgKindBright, norm,
                                {st_d.night_flag, 6'b000000, st_d.headlights_on},
                                8'h00, 8'h00);
        burst_o.msg[1] = burst_o.msg[0];
        if (st_d.dash_brightness != st_q.dash_brightness
            || st_d.headlights_on != st_q.headlights_on
            || st_d.night_flag != st_q.night_flag) begin
          burst_o.cnt = door_cnt;
        end
      end
      FrameLamps: begin
        st_d.front_lamp_bits = front_new;
        st_d.rear_lamp_bits  = rear_new;
        st_d.door_bits[5]    = hood_new;
        doors_item = mk_msg(LenDoors, MsgKindDoors, st_d.door_bits, 8'h00, 8'h00, 8'h00);
        if (front_new != st_q.front_lamp_bits || rear_new != st_q.rear_lamp_bits) begin
          burst_o.msg[0] = mk_msg(LenLamps, MsgKindLamps, front_new, rear_new,
                                  8'h00, 8'h00);
          burst_o.msg[1] = doors_item;
          burst_o.msg[2] = doors_item;
          burst_o.cnt    = (hood_new != st_q.door_bits[5]) ? (2'd1 + door_cnt) : 2'd1;
        end else begin
          burst_o.msg[0] = doors_item;
          burst_o.msg[1] = doors_item;
          burst_o.cnt    = (hood_new != st_q.door_bits[5]) ? door_cnt : 2'd0;
        end
      end
      FrameSpeed: begin
        st_d.speed_value = frame_i.data_0;
        burst_o.msg[0] = mk_msg(LenSpeed, MsgKindGauge, GaugeSpeed, SpeedUnit,
                                frame_i.data_0, 8'h00);
        if (frame_i.data_0 != st_q.speed_value) begin
          burst_o.cnt = 2'd1;
        end
      end
      FrameTemp: begin
        st_d.source_fahrenheit  = frame_i.data_0[1];
        st_d.raw_outside_temp   = frame_i.data_2;
        st_d.shown_outside_temp = shown_new;
        burst_o.msg[0] = mk_msg(LenTemp, MsgKindGauge, GaugeTemp, temp_flags,
                                {3'b000, temp.mag[12:8]}, temp.mag[7:0]);
        if (st_d.source_fahrenheit != st_q.source_fahrenheit
            || st_d.raw_outside_temp != st_q.raw_outside_temp
            || shown_new != st_q.shown_outside_temp) begin
          burst_o.cnt = 2'd1;
        end
      end
      FrameCoolant: begin
        st_d.raw_coolant_temp = frame_i.data_0;
        burst_o.msg[0] = mk_msg(LenCoolant, MsgKindGauge, GaugeCoolant,
                                CoolFlagBase | (cool_low ? CoolFlagNeg : 8'h00),
                                cool_mag, 8'h00);
        if (frame_i.data_0 != st_q.raw_coolant_temp) begin
          burst_o.cnt = 2'd1;
        end
      end
      FrameNone: begin
        burst_o.cnt = 2'd0;
      end
      default: begin
        burst_o.cnt = 2'd0;
      end
    endcase
    // mark the final message of the burst
    for (int i = 0; i < MaxMsgs; i++) begin
      burst_o.msg[i].last = (burst_o.cnt == 2'(i + 1));
    end
  end

  // stored vehicle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.key_position       <= KeyPosOff;
      st_q.door_bits          <= '0;
      st_q.dash_brightness    <= BrightReset;
      st_q.headlights_on      <= 1'b0;
      st_q.night_flag         <= 1'b0;
      st_q.front_lamp_bits    <= '0;
      st_q.rear_lamp_bits     <= '0;
      st_q.speed_value        <= '0;
      st_q.raw_outside_temp   <= '0;
      st_q.source_fahrenheit  <= 1'b0;
      st_q.shown_outside_temp <= ShownTempReset;
      st_q.raw_coolant_temp   <= CoolantReset;
    end else if (load_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* hdl/cfsg_msg_queue.sv */
module cfsg_msg_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cfsg_pkg::msg_burst_t  burst_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cfsg_pkg::out_item_t   out_data_o
);
  import cfsg_pkg::*;

  logic [1:0]              cnt_q;
  out_item_t [MaxMsgs-1:0] msg_q;
  logic                    take;

  // head of the burst is always in slot 0
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = msg_q[0];
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);

  // message count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= burst_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // message slots, shifted down on each transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= burst_i.msg;
    end else if (take) begin
      msg_q[0] <= msg_q[1];
      msg_q[1] <= msg_q[2];
    end
  end

endmodule

/* hdl/can_frame_to_status_message_gateway_core.sv */
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_stall_o    cfsg_pkg::in_item_t, one received frame
// out      out  out_valid_o / out_stall_i  cfsg_pkg::out_item_t, one status message
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_data_i, show_celsius
//
// A frame is held in the input register, then is decoded, updates the
// stored state and loads its 0 to 3 messages into the message queue together.
// The queue sends one message per cycle while the output does not stall, and it takes
// the next frame's burst as its last message leaves: the message queue sets the rate.
// Reset is asynchronous, active low, and restores all stored vehicle state.
// A stall on the output holds the queue; the input stalls only once the input
// register is full and the queue cannot take its burst.
module can_frame_to_status_message_gateway_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cfsg_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfsg_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);
  import cfsg_pkg::*;

  logic        in_vld_q;
  in_item_t    in_q;
  logic        show_celsius_q;
  logic        free;
  logic        load;
  logic        in_take;
  msg_burst_t  burst;

  // input register handshake
  assign load       = in_vld_q && free;
  assign in_stall_o = in_vld_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // display unit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_celsius_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      show_celsius_q <= cfg_data_i;
    end
  end

  // decode and state update
  cfsg_frame_proc u_frame_proc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .show_celsius_i (show_celsius_q),
    .frame_i        (in_q),
    .burst_o        (burst)
  );

  // message queue and output
  cfsg_msg_queue u_msg_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* dv/status_msg_checker.sv */
// watches the frame, message and unit channels, keeps its own copy of the
// vehicle state and checks every status message against the predicted stream
module status_msg_checker
  import cfsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // shadow vehicle state and unit setting
  logic       celsius_q;
  logic [2:0] key_q;
  logic [7:0] doors_q;
  logic [4:0] bright_q;
  logic       lights_q;
  logic       night_q;
  logic [7:0] front_q;
  logic [7:0] rear_q;
  logic [7:0] speed_q;
  logic [7:0] raw_temp_q;
  logic       src_fahr_q;
  int         shown_temp_q;
  logic [7:0] coolant_q;

  // messages still owed by the block, oldest first
  out_item_t  status_msgs_due[$];
  out_item_t  burst[MaxMsgs];
  int         burst_n;

  function automatic out_item_t make_msg(input logic [2:0] len, input logic [7:0] kind,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [7:0] b4, input logic [7:0] b5);
    out_item_t m;
    m.msg_len = len;
    m.byte_0  = BroadcastPrefix;
    m.byte_1  = kind;
    m.byte_2  = b2;
    m.byte_3  = b3;
    m.byte_4  = b4;
    m.byte_5  = b5;
    m.last    = 1'b0;
    return m;
  endfunction

  function automatic string msg_text(input out_item_t m);
    return $sformatf("len %0d bytes %h %h %h %h %h %h last %0b", m.msg_len, m.byte_0,
                     m.byte_1, m.byte_2, m.byte_3, m.byte_4, m.byte_5, m.last);
  endfunction

  // cut to a whole degree, or to the half degree once the tenths reach five
  function automatic int round_half(input int tenths);
    if (tenths % 10 >= 5) return (tenths / 10) * 10 + 5;
    return (tenths / 10) * 10;
  endfunction

  task automatic queue_msg(input out_item_t m);
    burst[burst_n] = m;
    burst_n++;
  endtask

  // doors are repeated while the key is off
  task automatic queue_doors();
    repeat ((key_q == KeyPosOff) ? 2 : 1)
      queue_msg(make_msg(LenDoors, MsgKindDoors, doors_q, 8'h00, 8'h00, 8'h00));
  endtask

  // update the shadow state from one frame and queue the messages it causes
  task automatic predict_status_msgs(input in_item_t f);
    logic [2:0] key_was;
    logic [7:0] doors_was;
    logic [4:0] bright_was;
    logic       lights_was;
    logic       night_was;
    logic [7:0] front_was;
    logic [7:0] rear_was;
    logic [7:0] raw_was;
    logic       fahr_was;
    int         shown_was;
    int         deci;
    logic [7:0] norm;
    logic [7:0] flags;
    logic [15:0] mag;

    burst_n = 0;
    if (f.frame_id == KeyFrameId && f.frame_len == KeyFrameLen) begin
      key_was = key_q;
      case (f.data_2)
        KeyCodeRun:               key_q = KeyPosRun;
        KeyCodeAccA, KeyCodeAccB: key_q = KeyPosAcc;
        KeyCodeLocked:            key_q = KeyPosLocked;
        default: ;
      endcase
      if (key_q != key_was)
        repeat ((key_was == KeyPosOff) ? 2 : 1)
          queue_msg(make_msg(LenKey, MsgKindKey, {5'd0, key_q}, 8'h00, 8'h00, 8'h00));
    end else if ((f.frame_id == DoorAFrameId || f.frame_id == DoorBFrameId ||
                  f.frame_id == DoorCFrameId) && f.frame_len == DoorFrameLen) begin
      doors_was = doors_q;
      if (f.frame_id == DoorAFrameId) begin
        doors_q[1] = f.data_0[5];
        doors_q[3] = f.data_0[7];
      end else if (f.frame_id == DoorBFrameId) begin
        doors_q[0] = f.data_0[4];
        doors_q[2] = f.data_0[6];
      end else begin
        doors_q[4] = f.data_0[7];
      end
      if (doors_q != doors_was) queue_doors();
    end else if (f.frame_id == BrightFrameId && f.frame_len == BrightFrameLen) begin
      bright_was = bright_q;
      lights_was = lights_q;
      night_was  = night_q;
      bright_q   = f.data_0[4:0];
      lights_q   = f.data_0[6];
      night_q    = f.data_5[6];
      if (bright_q != bright_was || lights_q != lights_was || night_q != night_was) begin
        norm  = (bright_q >= BrightFull) ? NormFull : bright_q * 8'd11;
        flags = {night_q, 6'd0, lights_q};
        repeat ((key_q == KeyPosOff) ? 2 : 1)
          queue_msg(make_msg(LenBright, MsgKindBright, norm, flags, 8'h00, 8'h00));
      end
    end else if (f.frame_id == LampFrameId && f.frame_len == LampFrameLen) begin
      front_was = front_q;
      rear_was  = rear_q;
      // fog, side, high, low, drl from the top bit down
      front_q = {3'b000, f.data_1[7], f.data_0[6], f.data_0[0], f.data_0[1], f.data_0[3]};
      rear_q  = {2'b00, f.data_1[6], f.data_1[3], 4'b0000};
      if (front_q != front_was || rear_q != rear_was)
        queue_msg(make_msg(LenLamps, MsgKindLamps, front_q, rear_q, 8'h00, 8'h00));
      // hood lives in the door bits and follows the lamp message
      if (doors_q[5] != f.data_0[7]) begin
        doors_q[5] = f.data_0[7];
        queue_doors();
      end
    end else if (f.frame_id == SpeedFrameId && f.frame_len == SpeedFrameLen) begin
      if (f.data_0 != speed_q) begin
        speed_q = f.data_0;
        queue_msg(make_msg(LenSpeed, MsgKindGauge, GaugeSpeed, SpeedUnit, speed_q, 8'h00));
      end
    end else if (f.frame_id == TempFrameId && f.frame_len == TempFrameLen) begin
      raw_was    = raw_temp_q;
      fahr_was   = src_fahr_q;
      shown_was  = shown_temp_q;
      src_fahr_q = f.data_0[1];
      raw_temp_q = f.data_2;
      deci       = (int'(raw_temp_q) - int'(RawOffset)) * 10;
      // same unit on both sides: no conversion; 320 tenths is the freezing point
      if (celsius_q != src_fahr_q) shown_temp_q = deci;
      else if (celsius_q)          shown_temp_q = round_half((deci - 320) * 5 / 9);
      else                         shown_temp_q = round_half(deci * 9 / 5 + 320);
      if (raw_temp_q != raw_was || src_fahr_q != fahr_was || shown_temp_q != shown_was) begin
        mag   = 16'((shown_temp_q < 0) ? -shown_temp_q : shown_temp_q);
        flags = TempFlagBase | ((shown_temp_q < 0) ? TempFlagNeg : 8'h00) |
                (celsius_q ? 8'h00 : TempFlagFahr);
        queue_msg(make_msg(LenTemp, MsgKindGauge, GaugeTemp, flags, mag[15:8], mag[7:0]));
      end
    end else if (f.frame_id == CoolantFrameId && f.frame_len == CoolantFrameLen) begin
      if (f.data_0 != coolant_q) begin
        coolant_q = f.data_0;
        if (coolant_q < CoolOffset)
          queue_msg(make_msg(LenCoolant, MsgKindGauge, GaugeCoolant,
                             CoolFlagBase | CoolFlagNeg, CoolOffset - coolant_q, 8'h00));
        else
          queue_msg(make_msg(LenCoolant, MsgKindGauge, GaugeCoolant,
                             CoolFlagBase, coolant_q - CoolOffset, 8'h00));
      end
    end

    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) status_msgs_due.push_back(burst[i]);
  endtask

  // compare one message transfer against the oldest owed message
  task automatic check_status_msg(input out_item_t got);
    out_item_t want;
    if (status_msgs_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected status message: %s", msg_text(got));
      return;
    end
    want = status_msgs_due.pop_front();
    if (got.msg_len !== want.msg_len || got.byte_0 !== want.byte_0 ||
        got.byte_1 !== want.byte_1 || got.byte_2 !== want.byte_2 ||
        got.byte_3 !== want.byte_3 || got.byte_4 !== want.byte_4 ||
        got.byte_5 !== want.byte_5 || got.last !== want.last) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("status message mismatch: expected %s, got %s", msg_text(want),
                 msg_text(got));
    end
  endtask

  // message transfers first, then unit writes, then frame transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      celsius_q    = 1'b0;
      key_q        = KeyPosOff;
      doors_q      = 8'h00;
      bright_q     = BrightReset;
      lights_q     = 1'b0;
      night_q      = 1'b0;
      front_q      = 8'h00;
      rear_q       = 8'h00;
      speed_q      = 8'h00;
      raw_temp_q   = 8'h00;
      src_fahr_q   = 1'b0;
      shown_temp_q = int'(ShownTempReset);
      coolant_q    = CoolantReset;
      status_msgs_due.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_status_msg(out_data_i);
      if (cfg_valid_i && cfg_ready_i) celsius_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_status_msgs(in_data_i);
    end
    pending_o = status_msgs_due.size();
  end

endmodule

/* dv/testbench.sv */
module testbench;
  import cfsg_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  int        fail_count;
  int        pending;

  // no idling on either side while set
  bit        calm;
  // receiver hold-off requests and the ones it has served
  int        hold_req;
  int        hold_done;
  in_item_t  last_frame;
  bit        have_last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  can_frame_to_status_message_gateway_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  status_msg_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // run limit
  initial begin
    #100000;
    $display("*** FAILED ***");
    $finish;
  end

  // message receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  // data bytes packed with byte 0 on top
  function automatic in_item_t frame(input logic [31:0] id, input logic [3:0] len,
                                     input logic [63:0] bytes);
    in_item_t f;
    f.frame_id  = id;
    f.frame_len = len;
    {f.data_0, f.data_1, f.data_2, f.data_3, f.data_4, f.data_5, f.data_6, f.data_7} = bytes;
    return f;
  endfunction

  // offer one frame after a random gap and hold it until the transfer
  task automatic send_frame(input in_item_t f);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every owed message is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_unit(input logic celsius);
    cfg_valid <= 1'b1;
    cfg_data  <= celsius;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed frames with random content; the rest noise, repeats
  // of the previous frame, or frames with a broken length or identifier
  task automatic random_frame(output in_item_t f);
    int pick;
    f = frame($urandom, 4'($urandom_range(15)), {$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 8) begin
      return;
    end
    if (pick < 18 && have_last) begin
      f = last_frame;
      return;
    end
    case ($urandom_range(8))
      0: begin
        f.frame_id  = KeyFrameId;
        f.frame_len = KeyFrameLen;
        case ($urandom_range(4))
          0: f.data_2 = KeyCodeRun;
          1: f.data_2 = KeyCodeAccA;
          2: f.data_2 = KeyCodeAccB;
          3: f.data_2 = KeyCodeLocked;
          default: ;
        endcase
      end
      1: begin f.frame_id = DoorAFrameId;   f.frame_len = DoorFrameLen;    end
      2: begin f.frame_id = DoorBFrameId;   f.frame_len = DoorFrameLen;    end
      3: begin f.frame_id = DoorCFrameId;   f.frame_len = DoorFrameLen;    end
      4: begin f.frame_id = BrightFrameId;  f.frame_len = BrightFrameLen;  end
      5: begin f.frame_id = LampFrameId;    f.frame_len = LampFrameLen;    end
      6: begin f.frame_id = SpeedFrameId;   f.frame_len = SpeedFrameLen;   end
      7: begin f.frame_id = TempFrameId;    f.frame_len = TempFrameLen;    end
      default: begin f.frame_id = CoolantFrameId; f.frame_len = CoolantFrameLen; end
    endcase
    if (pick < 28) begin
      if ($urandom_range(1)) f.frame_len = f.frame_len ^ 4'($urandom_range(15, 1));
      else                   f.frame_id  = f.frame_id ^ (32'd1 << $urandom_range(31));
    end else begin
      last_frame = f;
      have_last  = 1'b1;
    end
  endtask

  // stimulus and verdict
  initial begin
    in_item_t f;

    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    calm      = 1'b0;
    hold_req  = 0;
    have_last = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_unit(1'b0);

    // key still off: doors, brightness and hood come twice
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0000_0000_0000_0000));
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0200_FF00_0000_0000));
    send_frame(frame(DoorAFrameId, DoorFrameLen, 64'hA000_0000_0000_0000));
    send_frame(frame(DoorBFrameId, DoorFrameLen, 64'h5000_0000_0000_0000));
    send_frame(frame(DoorCFrameId, DoorFrameLen, 64'h8000_0000_0000_0000));
    send_frame(frame(BrightFrameId, BrightFrameLen, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(frame(BrightFrameId, BrightFrameLen, 64'h1500_0000_0000_0000));
    send_frame(frame(LampFrameId, LampFrameLen, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(frame(LampFrameId, LampFrameLen, 64'h0000_0000_0000_0000));
    // unlisted key byte keeps the key, then every key code
    send_frame(frame(KeyFrameId, KeyFrameLen, 64'h0000_5500_0000_0000));
    send_frame(frame(KeyFrameId, KeyFrameLen, 64'h0000_0200_0000_0000));
    send_frame(frame(KeyFrameId, KeyFrameLen, 64'h0000_4000_0000_0000));
    send_frame(frame(KeyFrameId, KeyFrameLen, 64'h0000_6000_0000_0000));
    send_frame(frame(KeyFrameId, KeyFrameLen, 64'h0000_0000_0000_0000));
    send_frame(frame(DoorCFrameId, DoorFrameLen, 64'h0000_0000_0000_0000));
    send_frame(frame(SpeedFrameId, SpeedFrameLen, 64'hFF00_0000_0000_0000));
    send_frame(frame(SpeedFrameId, SpeedFrameLen, 64'h0000_0000_0000_0000));
    send_frame(frame(CoolantFrameId, CoolantFrameLen, 64'h0000_0000_0000_0000));
    send_frame(frame(CoolantFrameId, CoolantFrameLen, 64'h2700_0000_0000_0000));
    send_frame(frame(CoolantFrameId, CoolantFrameLen, 64'h2800_0000_0000_0000));
    send_frame(frame(CoolantFrameId, CoolantFrameLen, 64'hFF00_0000_0000_0000));
    // unknown identifier, wrong length, extended flag cleared
    send_frame(frame(32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_frame(frame(KeyFrameId, 4'd4, 64'h0000_0200_0000_0000));
    send_frame(frame(KeyFrameId & 32'h7FFF_FFFF, KeyFrameLen, 64'h0000_0200_0000_0000));
    settle();

    // celsius shown: conversions from fahrenheit and a plain celsius source
    set_unit(1'b1);
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0200_4800_0000_0000));
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0200_0000_0000_0000));
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0200_FF00_0000_0000));
    send_frame(frame(TempFrameId, TempFrameLen, 64'h0000_2A00_0000_0000));

    // random phases, alternating the unit; a hold-off in one, no idling in another
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      set_unit(phase % 2 == 1);
      if (phase == 1) hold_req++;
      calm = (phase == 2);
      repeat (73) begin
        random_frame(f);
        send_frame(f);
      end
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cfsg_pkg.sv
hdl/cfsg_temp_conv.sv
hdl/cfsg_frame_proc.sv
hdl/cfsg_msg_queue.sv
hdl/can_frame_to_status_message_gateway_core.sv
dv/status_msg_checker.sv
dv/testbench.sv
